/* rtl/core/sliding_window_min_cover_dp_macros.svh */
// Assertion macros used by the checker file of the sliding window min cover block.
`ifndef SLIDING_WINDOW_MIN_COVER_DP_MACROS_SVH
`define SLIDING_WINDOW_MIN_COVER_DP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/swmc_pkg.sv */
// Package with widths, defaults and the sequencer state type of the min cover block.
`timescale 1ns / 1ps
package swmc_pkg;

   localparam int COST_W         = 16;
   localparam int DATA_W         = 32;
   localparam int REACH_W        = 5;
   localparam int SEEN_W         = 7;
   localparam int SEEN_MAX       = 127;
   localparam int DEF_MAX_REACH  = 31;
   localparam int DEF_RING_DEPTH = 64;
   localparam int REACH_RESET    = 1;

   localparam logic [DATA_W-1:0] SUM_MAX = {DATA_W{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

endpackage

/* rtl/core/sliding_window_min_cover_dp.sv */
// Top level of the sliding window min cover accumulator: sequencer, ring and result register.
//
//  channel   ports                               direction  handshake
//  request   req_cost, req_last                  in         req_valid / req_ready
//  response  rsp_min_total                       out        rsp_valid / rsp_ready
//  config    csr_wr_data (reach)                 in         csr_wr_en, no wait
//
// A request among the first reach+1 of a sequence is written to the ring directly; any other
// first scans n stored entries, with n = min(2*reach+1, items so far, ring depth), through the
// single ring read port that the window scan walks one entry a cycle, then writes its sum.
// A last request adds a final scan of up to reach+1 entries, then loads the response.
// Synchronous active-high reset clears control state; ring contents are never cleared.
// A new request is taken while a response waits; a finished sequence holds until the
// response register is free.
`timescale 1ns / 1ps
module sliding_window_min_cover_dp #(
   parameter int MAX_REACH  = swmc_pkg::DEF_MAX_REACH,
   parameter int RING_DEPTH = swmc_pkg::DEF_RING_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [swmc_pkg::COST_W-1:0]   req_cost,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [swmc_pkg::DATA_W-1:0]   rsp_min_total,
   input  logic                          csr_wr_en,
   input  logic [swmc_pkg::REACH_W-1:0]  csr_wr_data
);

   localparam int AW        = $clog2(RING_DEPTH);
   localparam int CW        = swmc_pkg::SEEN_W;
   localparam int KCAP      = (MAX_REACH < 31) ? MAX_REACH : 31;
   localparam int DEPTH_CAP = (RING_DEPTH < swmc_pkg::SEEN_MAX) ? RING_DEPTH
                                                                 : swmc_pkg::SEEN_MAX;

   swmc_pkg::state_type state_ff, state_in;

   logic [swmc_pkg::REACH_W-1:0] reach_ff, reach_in;
   logic [swmc_pkg::COST_W-1:0]  cost_ff, cost_in;
   logic                         last_ff, last_in;
   logic [swmc_pkg::DATA_W-1:0]  min_ff, min_in;
   logic [swmc_pkg::DATA_W-1:0]  val_ff, val_in;
   logic [AW-1:0]                scan_addr_ff, scan_addr_in;
   logic [CW-1:0]                left_ff, left_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic                         final_ff, final_in;
   logic [AW-1:0]                wp_ff, wp_in;
   logic [CW-1:0]                seen_ff, seen_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [swmc_pkg::DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [swmc_pkg::REACH_W-1:0] k_eff;
   logic [CW-1:0]                n_win;
   logic [CW-1:0]                n_fin;
   logic [CW-1:0]                k_ext;
   logic [CW-1:0]                win_w;
   logic [CW-1:0]                fin_w;
   logic [CW-1:0]                seen_inc;
   logic [AW-1:0]                wp_dec;
   logic [AW-1:0]                wp_inc;
   logic [AW-1:0]                scan_dec;
   logic                         rd_en;
   logic [swmc_pkg::DATA_W-1:0]  rd_data;
   logic [swmc_pkg::DATA_W-1:0]  min_nxt;
   logic [swmc_pkg::DATA_W:0]    sum;
   logic [swmc_pkg::DATA_W-1:0]  sum_sat;
   logic                         req_fire;
   logic                         rsp_free;

   assign req_ready = (state_ff == swmc_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // effective reach and scan lengths
   assign k_eff    = (reach_ff > swmc_pkg::REACH_W'(KCAP)) ? swmc_pkg::REACH_W'(KCAP)
                                                           : reach_ff;
   assign k_ext    = CW'(k_eff);
   assign win_w    = CW'({k_eff, 1'b1});
   assign fin_w    = k_ext + CW'(1);
   assign seen_inc = (seen_ff == CW'(swmc_pkg::SEEN_MAX)) ? seen_ff : seen_ff + CW'(1);

   always_comb begin
      n_win = win_w;
      if (seen_ff < n_win) begin
         n_win = seen_ff;
      end
      if (CW'(DEPTH_CAP) < n_win) begin
         n_win = CW'(DEPTH_CAP);
      end
      n_fin = fin_w;
      if (seen_inc < n_fin) begin
         n_fin = seen_inc;
      end
      if (CW'(DEPTH_CAP) < n_fin) begin
         n_fin = CW'(DEPTH_CAP);
      end
   end

   // ring pointer arithmetic with wrap for any depth
   assign wp_dec   = (wp_ff == '0) ? AW'(RING_DEPTH - 1) : wp_ff - AW'(1);
   assign wp_inc   = (wp_ff == AW'(RING_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
   assign scan_dec = (scan_addr_ff == '0) ? AW'(RING_DEPTH - 1) : scan_addr_ff - AW'(1);

   // running minimum and saturating sum
   assign min_nxt = (rd_vld_ff && (rd_data < min_ff)) ? rd_data : min_ff;
   assign sum     = {1'b0, min_nxt} + (swmc_pkg::DATA_W + 1)'(cost_ff);
   assign sum_sat = sum[swmc_pkg::DATA_W] ? swmc_pkg::SUM_MAX : sum[swmc_pkg::DATA_W-1:0];

   assign rd_en = (state_ff == swmc_pkg::ST_SCAN) && (left_ff != '0);

   swmc_ring #(
      .RING_DEPTH (RING_DEPTH),
      .AW         (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == swmc_pkg::ST_WRITE),
      .wr_addr (wp_ff),
      .wr_data (val_ff),
      .rd_en   (rd_en),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      reach_in     = reach_ff;
      cost_in      = cost_ff;
      last_in      = last_ff;
      min_in       = min_ff;
      val_in       = val_ff;
      scan_addr_in = scan_addr_ff;
      left_in      = left_ff;
      rd_vld_in    = 1'b0;
      final_in     = final_ff;
      wp_in        = wp_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         reach_in = csr_wr_data;
      end

      unique case (state_ff)
         swmc_pkg::ST_IDLE: begin
            if (req_fire) begin
               cost_in      = req_cost;
               last_in      = req_last;
               min_in       = swmc_pkg::SUM_MAX;
               scan_addr_in = wp_dec;
               left_in      = n_win;
               final_in     = 1'b0;
               if (seen_ff <= k_ext) begin
                  val_in   = swmc_pkg::DATA_W'(req_cost);
                  state_in = swmc_pkg::ST_WRITE;
               end else begin
                  state_in = swmc_pkg::ST_SCAN;
               end
            end
         end
         swmc_pkg::ST_SCAN: begin
            min_in = min_nxt;
            if (left_ff != '0) begin
               scan_addr_in = scan_dec;
               left_in      = left_ff - CW'(1);
               rd_vld_in    = 1'b1;
            end else if (rd_vld_ff) begin
               // last entry compared this cycle
               if (final_ff) begin
                  state_in = swmc_pkg::ST_OUT;
               end else begin
                  val_in   = sum_sat;
                  state_in = swmc_pkg::ST_WRITE;
               end
            end
         end
         swmc_pkg::ST_WRITE: begin
            if (last_ff) begin
               // the value just stored seeds the final minimum
               min_in       = val_ff;
               scan_addr_in = wp_dec;
               left_in      = n_fin - CW'(1);
               final_in     = 1'b1;
               wp_in        = '0;
               seen_in      = '0;
               state_in     = (n_fin == CW'(1)) ? swmc_pkg::ST_OUT : swmc_pkg::ST_SCAN;
            end else begin
               wp_in    = wp_inc;
               seen_in  = seen_inc;
               state_in = swmc_pkg::ST_IDLE;
            end
         end
         swmc_pkg::ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = min_ff;
               state_in     = swmc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swmc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swmc_pkg::ST_IDLE;
         reach_ff     <= swmc_pkg::REACH_W'(swmc_pkg::REACH_RESET);
         left_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         final_ff     <= 1'b0;
         wp_ff        <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reach_ff     <= reach_in;
         left_ff      <= left_in;
         rd_vld_ff    <= rd_vld_in;
         final_ff     <= final_in;
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cost_ff      <= cost_in;
      last_ff      <= last_in;
      min_ff       <= min_in;
      val_ff       <= val_in;
      scan_addr_ff <= scan_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_total = rsp_data_ff;

endmodule

/* rtl/core/swmc_ring.sv */
// Ring memory of stored values: one write port, one read port with registered data.
`timescale 1ns / 1ps
module swmc_ring #(
   parameter int RING_DEPTH = swmc_pkg::DEF_RING_DEPTH,
   parameter int AW         = $clog2(RING_DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [swmc_pkg::DATA_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [swmc_pkg::DATA_W-1:0] rd_data
);

   logic [swmc_pkg::DATA_W-1:0] mem [RING_DEPTH];
   logic [swmc_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/swmc_checker.sv */
// Port-level checker for the min cover block, bound to the top level.
`timescale 1ns / 1ps
`include "sliding_window_min_cover_dp_macros.svh"
module swmc_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_last,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [swmc_pkg::DATA_W-1:0] rsp_min_total
);

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   `SWMC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `SWMC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_min_total), "response changed while stalled")
   `SWMC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire, !req_ready, "request taken without a busy cycle")
   `SWMC_ASSERT_NEXT(a_no_rsp_mid_seq, clock, reset, req_fire && !req_last, !$rose(rsp_valid), "response raised by a request that is not last")

endmodule

bind sliding_window_min_cover_dp swmc_checker u_swmc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_last      (req_last),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_min_total (rsp_min_total)
);
